// File: rtl/core/hrlp_pkg.sv
package hrlp_pkg;

  // Longest request line, counted in bytes.
  localparam int unsigned MAX_LINE_BYTES = 8192;
  localparam int unsigned LINE_POS_W = $clog2(MAX_LINE_BYTES);
  localparam logic [LINE_POS_W-1:0] LAST_POS = LINE_POS_W'(MAX_LINE_BYTES - 1);

  // Configuration register indexes.
  localparam logic [1:0] CFG_IDX_BARE_LF = 2'd0;
  localparam logic [1:0] CFG_IDX_CUSTOM  = 2'd1;

  // Part tags.
  localparam logic [3:0] PART_METHOD     = 4'd0;
  localparam logic [3:0] PART_SPACE      = 4'd1;
  localparam logic [3:0] PART_SCHEME     = 4'd2;
  localparam logic [3:0] PART_SCHEME_DLM = 4'd3;
  localparam logic [3:0] PART_HOST       = 4'd4;
  localparam logic [3:0] PART_PORT_COLON = 4'd5;
  localparam logic [3:0] PART_PORT       = 4'd6;
  localparam logic [3:0] PART_PATH       = 4'd7;
  localparam logic [3:0] PART_QUERY_MARK = 4'd8;
  localparam logic [3:0] PART_QUERY      = 4'd9;
  localparam logic [3:0] PART_VERSION    = 4'd10;
  localparam logic [3:0] PART_LINE_END   = 4'd11;
  localparam logic [3:0] PART_REJECT     = 4'd12;

  // Status codes.
  localparam logic [1:0] ST_PROGRESS = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_BAD      = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  // Method codes.
  localparam logic [3:0] MC_GET     = 4'd0;
  localparam logic [3:0] MC_POST    = 4'd1;
  localparam logic [3:0] MC_PUT     = 4'd2;
  localparam logic [3:0] MC_HEAD    = 4'd3;
  localparam logic [3:0] MC_DELETE  = 4'd4;
  localparam logic [3:0] MC_CONNECT = 4'd5;
  localparam logic [3:0] MC_OPTIONS = 4'd6;
  localparam logic [3:0] MC_TRACE   = 4'd7;
  localparam logic [3:0] MC_CUSTOM  = 4'd8;
  localparam logic [3:0] MC_BAD     = 4'd15;

  // Method names as held in the prefix register: the first byte sits in the
  // low bits, so the strings are written back to front.
  localparam logic [55:0] NAME_GET     = 56'("TEG");
  localparam logic [55:0] NAME_PUT     = 56'("TUP");
  localparam logic [55:0] NAME_POST    = 56'("TSOP");
  localparam logic [55:0] NAME_HEAD    = 56'("DAEH");
  localparam logic [55:0] NAME_DELETE  = 56'("ETELED");
  localparam logic [55:0] NAME_CONNECT = 56'("TCENNOC");
  localparam logic [55:0] NAME_OPTIONS = 56'("SNOITPO");
  localparam logic [55:0] NAME_TRACE   = 56'("ECART");

  localparam logic [31:0] PFX_POST = 32'("TSOP");
  localparam logic [31:0] PFX_HEAD = 32'("DAEH");
  localparam logic [31:0] PFX_DELE = 32'("ELED");
  localparam logic [31:0] PFX_CONN = 32'("NNOC");
  localparam logic [31:0] PFX_OPTI = 32'("ITPO");
  localparam logic [31:0] PFX_TRAC = 32'("CART");

  // Parser phases.
  typedef enum logic [4:0] {
    PH_METHOD     = 5'd0,
    PH_MCUSTOM    = 5'd1,
    PH_TARGET     = 5'd2,
    PH_SCHEME     = 5'd3,
    PH_SL1        = 5'd4,
    PH_SL2        = 5'd5,
    PH_HOST_START = 5'd6,
    PH_REG        = 5'd7,
    PH_IP         = 5'd8,
    PH_HOST_END   = 5'd9,
    PH_PORT       = 5'd10,
    PH_PATH       = 5'd11,
    PH_QUERY      = 5'd12,
    PH_VER0       = 5'd13,
    PH_VER1       = 5'd14,
    PH_VER2       = 5'd15,
    PH_VER3       = 5'd16,
    PH_VER4       = 5'd17,
    PH_VMAJ       = 5'd18,
    PH_VDOT       = 5'd19,
    PH_VMIN       = 5'd20,
    PH_EOL        = 5'd21
  } hrlp_phase_e;

  // Input item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } hrlp_in_t;

  // Result item.
  typedef struct packed {
    logic [3:0]  part;
    logic [1:0]  status;
    logic [3:0]  method_code;
    logic [3:0]  version_major;
    logic [3:0]  version_minor;
    logic [12:0] byte_offset;
  } hrlp_out_t;

  // Configuration registers.
  typedef struct packed {
    logic allow_bare_lf;
    logic allow_custom_method;
  } hrlp_cfg_t;

  // Per-line parser state.
  typedef struct packed {
    hrlp_phase_e           phase;
    logic [55:0]           prefix;
    logic [2:0]            mlen;
    logic [3:0]            mfound;
    logic [LINE_POS_W-1:0] pos;
    logic [3:0]            major;
    logic [3:0]            minor;
    logic                  seen_cr;
  } hrlp_line_t;

  localparam hrlp_line_t LINE_RESET = '{
    phase:   PH_METHOD,
    prefix:  '0,
    mlen:    '0,
    mfound:  '0,
    pos:     '0,
    major:   '0,
    minor:   '0,
    seen_cr: 1'b0
  };

endpackage

// File: rtl/core/hrlp_step.sv
module hrlp_step import hrlp_pkg::*; (
  input  hrlp_cfg_t  cfg_i,
  input  hrlp_line_t state_i,
  input  hrlp_in_t   in_i,
  output hrlp_line_t state_o,
  output hrlp_out_t  res_o
);

  // Character classes.
  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || is_digit(c);
  endfunction

  function automatic logic is_method_ch(input logic [7:0] c);
    return c inside {["A":"Z"], "_", "-"};
  endfunction

  function automatic logic is_scheme_ch(input logic [7:0] c);
    return is_alnum(c) || (c inside {"+", "-", "."});
  endfunction

  function automatic logic is_ip_ch(input logic [7:0] c);
    return is_alnum(c) || (c == ":");
  endfunction

  function automatic logic is_reg_ch(input logic [7:0] c);
    return is_alnum(c) || (c inside {"-", ".", "_", "~", "%", "!", "$", "&", "'",
                                     "(", ")", "*", "+", ",", ";", "="});
  endfunction

  function automatic logic is_pchar(input logic [7:0] c);
    return is_reg_ch(c) || (c inside {":", "@"});
  endfunction

  // True when the first four method bytes start one of the longer known names.
  function automatic logic reserved_prefix(input logic [31:0] p4);
    return (p4 == PFX_POST) || (p4 == PFX_HEAD) || (p4 == PFX_DELE) ||
           (p4 == PFX_CONN) || (p4 == PFX_OPTI) || (p4 == PFX_TRAC);
  endfunction

  // Method code of a complete token.
  function automatic logic [3:0] classify(input logic [55:0] p, input logic [2:0] n);
    logic [3:0] code;
    code = MC_CUSTOM;
    if (n == 3'd0) begin
      code = MC_BAD;
    end else if (n == 3'd3 && p == NAME_GET) begin
      code = MC_GET;
    end else if (n == 3'd3 && p == NAME_PUT) begin
      code = MC_PUT;
    end else if (n >= 3'd4 && reserved_prefix(p[31:0])) begin
      if (n == 3'd4 && p == NAME_POST) code = MC_POST;
      else if (n == 3'd4 && p == NAME_HEAD) code = MC_HEAD;
      else if (n == 3'd6 && p == NAME_DELETE) code = MC_DELETE;
      else if (n == 3'd7 && p == NAME_CONNECT) code = MC_CONNECT;
      else if (n == 3'd7 && p == NAME_OPTIONS) code = MC_OPTIONS;
      else if (n == 3'd5 && p == NAME_TRACE) code = MC_TRACE;
      else code = MC_BAD;
    end
    return code;
  endfunction

  // Expected byte of the "HTTP/" text in each version phase.
  function automatic logic [7:0] ver_char(input hrlp_phase_e ph);
    logic [7:0] ch;
    case (ph)
      PH_VER0: ch = "H";
      PH_VER1: ch = "T";
      PH_VER2: ch = "T";
      PH_VER3: ch = "P";
      default: ch = "/";
    endcase
    return ch;
  endfunction

  hrlp_line_t  cur;
  hrlp_line_t  upd;
  logic [7:0]  c;
  logic [3:0]  part;
  logic [3:0]  code;
  logic [1:0]  status;
  logic        done;

  // The byte after a host or a port.
  function automatic logic [3:0] auth_part(input logic [7:0] ch, input logic port_ok);
    logic [3:0] p;
    if (ch == ":" && port_ok) p = PART_PORT_COLON;
    else if (ch == "/") p = PART_PATH;
    else if (ch == "?") p = PART_QUERY_MARK;
    else if (ch == " ") p = PART_SPACE;
    else p = PART_REJECT;
    return p;
  endfunction

  function automatic hrlp_phase_e auth_phase(input logic [7:0] ch, input logic port_ok,
                                             input hrlp_phase_e ph);
    hrlp_phase_e n;
    if (ch == ":" && port_ok) n = PH_PORT;
    else if (ch == "/") n = PH_PATH;
    else if (ch == "?") n = PH_QUERY;
    else if (ch == " ") n = PH_VER0;
    else n = ph;
    return n;
  endfunction

  // Phase decode for one byte.
  always_comb begin
    cur  = in_i.restart ? LINE_RESET : state_i;
    c    = in_i.data_byte;
    upd  = cur;
    part = PART_REJECT;
    done = 1'b0;
    code = classify(cur.prefix, cur.mlen);
    case (cur.phase)
      PH_METHOD: begin
        if (is_method_ch(c)) begin
          if (cur.mlen != 3'd7) begin
            upd.prefix[{cur.mlen, 3'b000} +: 8] = c;
            upd.mlen = cur.mlen + 3'd1;
            part = PART_METHOD;
          end else if (!reserved_prefix(cur.prefix[31:0]) && cfg_i.allow_custom_method) begin
            upd.mfound = MC_CUSTOM;
            upd.phase  = PH_MCUSTOM;
            part = PART_METHOD;
          end
        end else if (c == " ") begin
          if (code != MC_BAD && (code != MC_CUSTOM || cfg_i.allow_custom_method)) begin
            upd.mfound = code;
            upd.phase  = (code == MC_CONNECT) ? PH_HOST_START : PH_TARGET;
            part = PART_SPACE;
          end
        end
      end
      PH_MCUSTOM: begin
        if (is_method_ch(c)) begin
          part = PART_METHOD;
        end else if (c == " ") begin
          upd.phase = PH_TARGET;
          part = PART_SPACE;
        end
      end
      PH_TARGET: begin
        if (c == "/") begin
          upd.phase = PH_PATH;
          part = PART_PATH;
        end else if (is_alpha(c)) begin
          upd.phase = PH_SCHEME;
          part = PART_SCHEME;
        end
      end
      PH_SCHEME: begin
        if (is_scheme_ch(c)) begin
          part = PART_SCHEME;
        end else if (c == ":") begin
          upd.phase = PH_SL1;
          part = PART_SCHEME_DLM;
        end
      end
      PH_SL1: begin
        if (c == "/") begin
          upd.phase = PH_SL2;
          part = PART_SCHEME_DLM;
        end
      end
      PH_SL2: begin
        if (c == "/") begin
          upd.phase = PH_HOST_START;
          part = PART_SCHEME_DLM;
        end
      end
      PH_HOST_START, PH_REG: begin
        if (cur.phase == PH_HOST_START && c == "[") begin
          upd.phase = PH_IP;
          part = PART_HOST;
        end else if (is_reg_ch(c)) begin
          upd.phase = PH_REG;
          part = PART_HOST;
        end else begin
          part = auth_part(c, 1'b1);
          upd.phase = auth_phase(c, 1'b1, cur.phase);
        end
      end
      PH_IP: begin
        if (is_ip_ch(c)) begin
          part = PART_HOST;
        end else if (c == "]") begin
          upd.phase = PH_HOST_END;
          part = PART_HOST;
        end
      end
      PH_HOST_END: begin
        part = auth_part(c, 1'b1);
        upd.phase = auth_phase(c, 1'b1, cur.phase);
      end
      PH_PORT: begin
        if (is_digit(c)) begin
          part = PART_PORT;
        end else begin
          part = auth_part(c, 1'b0);
          upd.phase = auth_phase(c, 1'b0, cur.phase);
        end
      end
      PH_PATH: begin
        if (is_pchar(c) || c == "/") begin
          part = PART_PATH;
        end else if (c == "?") begin
          upd.phase = PH_QUERY;
          part = PART_QUERY_MARK;
        end else if (c == " ") begin
          upd.phase = PH_VER0;
          part = PART_SPACE;
        end
      end
      PH_QUERY: begin
        if (is_pchar(c) || c == "/" || c == "?") begin
          part = PART_QUERY;
        end else if (c == " ") begin
          upd.phase = PH_VER0;
          part = PART_SPACE;
        end
      end
      PH_VER0, PH_VER1, PH_VER2, PH_VER3, PH_VER4: begin
        if (c == ver_char(cur.phase)) begin
          upd.phase = hrlp_phase_e'(cur.phase + 5'd1);
          part = PART_VERSION;
        end
      end
      PH_VMAJ: begin
        if (is_digit(c)) begin
          upd.major = c[3:0];
          upd.phase = PH_VDOT;
          part = PART_VERSION;
        end
      end
      PH_VDOT: begin
        if (c == ".") begin
          upd.phase = PH_VMIN;
          part = PART_VERSION;
        end
      end
      PH_VMIN: begin
        if (is_digit(c)) begin
          upd.minor = c[3:0];
          upd.phase = PH_EOL;
          part = PART_VERSION;
        end
      end
      PH_EOL: begin
        if (!cur.seen_cr && c == 8'h0d) begin
          upd.seen_cr = 1'b1;
          part = PART_LINE_END;
        end else if (c == 8'h0a && (cur.seen_cr || cfg_i.allow_bare_lf)) begin
          part = PART_LINE_END;
          done = 1'b1;
        end
      end
      default: begin
        part = PART_REJECT;
      end
    endcase
  end

  // Status, result item and the state left for the next byte.
  always_comb begin
    res_o  = '0;
    status = ST_PROGRESS;
    if (part == PART_REJECT) begin
      status = ST_BAD;
    end else if (done) begin
      status = ST_COMPLETE;
    end else if (cur.pos >= LAST_POS) begin
      status = ST_TOO_LONG;
    end

    res_o.part          = (status == ST_TOO_LONG) ? PART_REJECT : part;
    res_o.status        = status;
    res_o.method_code   = upd.mfound;
    res_o.version_major = done ? upd.major : 4'd0;
    res_o.version_minor = done ? upd.minor : 4'd0;
    res_o.byte_offset   = 13'(cur.pos);

    if (status != ST_PROGRESS) begin
      state_o = LINE_RESET;
    end else begin
      state_o     = upd;
      state_o.pos = cur.pos + 1'b1;
    end
  end

endmodule

// File: rtl/core/http_request_line_parser.sv
// HTTP request line tagger: one byte in, one tagged result item out.
// Input channel: in_valid_i / in_stall_o with in_data_i (byte and restart
// flag). An item is taken at a clock edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i with out_data_o (part, status,
// method code, version digits and byte offset of the byte).
// Configuration channel: cfg_valid_i / cfg_ready_o with cfg_index_i and
// cfg_wdata_i; ready is always high. Index 0 is allow_bare_lf, index 1
// allow_custom_method; other indexes are ignored. Write only while idle.
// An accepted byte sits in the input register, and the phase decode then loads
// its result into the result register.
// Throughput: one byte per cycle while out_stall_i is low; the per-line state
// takes a single decode step per accepted byte, so bytes stream back to back.
// While the receiver stalls, the held result stays put and one more byte can
// be accepted into the input register; after that in_stall_o rises.
// Reset clears both pipeline stages, sets both configuration bits to one and
// puts the parser at the start of a method.
module http_request_line_parser import hrlp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  hrlp_in_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output hrlp_out_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic       cfg_wdata_i
);

  logic       in_valid_q;
  hrlp_in_t   in_q;
  logic       out_valid_q;
  hrlp_out_t  out_q;
  hrlp_line_t state_q;
  hrlp_line_t state_d;
  hrlp_out_t  res_d;
  hrlp_cfg_t  cfg_q;
  logic       advance;

  // The input stage moves on when the result register is empty or drained.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // Decode of one byte against the line state.
  hrlp_step u_step (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .in_i    (in_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{allow_bare_lf: 1'b1, allow_custom_method: 1'b1};
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_IDX_BARE_LF) cfg_q.allow_bare_lf <= cfg_wdata_i;
      if (cfg_index_i == CFG_IDX_CUSTOM) cfg_q.allow_custom_method <= cfg_wdata_i;
    end
  end

  // Pipeline control and line state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= LINE_RESET;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

`ifndef SYNTHESIS
  // A completed line always ends on a line-end byte; an overlong one is rejected.
  a_status_part: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_COMPLETE || out_data_o.status == ST_TOO_LONG)
    |-> (out_data_o.part == PART_LINE_END && out_data_o.status == ST_COMPLETE) ||
        (out_data_o.part == PART_REJECT && out_data_o.status == ST_TOO_LONG))
    else $error("part does not match status");

  // Version digits show only on the completing byte.
  a_version_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_COMPLETE
    |-> out_data_o.version_major == 4'd0 && out_data_o.version_minor == 4'd0)
    else $error("version digits outside a completed line");

  // A finished or rejected line restarts the byte count.
  a_line_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.status != ST_PROGRESS |=> state_q.pos == '0)
    else $error("line state not cleared after line end");

  // Input stalls only behind a blocked result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && out_stall_i && in_valid_q)
    else $error("input stalled without a blocked result");
`endif

endmodule
